@@ hw/rtl/undirected_cycle_finder_core_defines.svh @@
// Assertion macros used by the checker file of the cycle finder.
// Depends on nothing; included by the bound checker.
`ifndef UNDIRECTED_CYCLE_FINDER_CORE_DEFINES_SVH
`define UNDIRECTED_CYCLE_FINDER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define UCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define UCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/ucf_pkg.sv @@
// Package of the cycle finder: capacities, payload structs, FSM state type.
// Depends on nothing.
`timescale 1ns / 1ps
package ucf_pkg;
  // Capacities; node indices are 5 bits wide in the payload structs
  localparam int MaxNodes = 32;
  localparam int MaxEdges = 256;

  typedef struct packed {
    logic [4:0] edge_a;
    logic [4:0] edge_b;
    logic       has_edge;
    logic       last_edge;
  } edge_item_t;

  typedef struct packed {
    logic       found;
    logic [5:0] cycle_length;
    logic [4:0] vertex;
    logic       overflow;
    logic       last;
  } result_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_TOP,
    ST_SCAN,
    ST_EDGE,
    ST_VISIT,
    ST_WALK,
    ST_WALK_RD,
    ST_EMIT,
    ST_CLEAR
  } state_e;
endpackage

@@ hw/rtl/ucf_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module ucf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hw/rtl/undirected_cycle_finder_core.sv @@
// Top level of the undirected cycle finder: edge loader, DFS sequencer, emitter.
// Depends on ucf_pkg and ucf_ram.
//
// channel  direction  handshake            payload
// cfg      in         node_count_we_i      node_count_i
// edge     in         start_i & !busy_o    edge_i
// result   out        result_valid_o       result_o
//
// A plain edge is taken and the block stays idle. After the last edge busy_o
// holds for the search: each root tried (ST_ROOT), each stack visit (stack read
// in ST_TOP, entry in ST_SCAN) with each edge scanned (ST_EDGE) and each neighbor
// handled (ST_VISIT), the parent walk per vertex (ST_WALK, ST_WALK_RD), then each
// result (ST_EMIT) and a clear (ST_CLEAR) of the visited marks and counters at once.
// Reset clears all control state at once and sets the node count to 32; results cannot be stalled.
`timescale 1ns / 1ps
module undirected_cycle_finder_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   node_count_we_i,
  input  logic [5:0]             node_count_i,
  input  logic                   start_i,
  input  ucf_pkg::edge_item_t    edge_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output ucf_pkg::result_item_t  result_o
);
  import ucf_pkg::*;

  localparam int NW = $clog2(MaxNodes);
  localparam int EW = $clog2(MaxEdges);
  localparam int CW = $clog2(MaxEdges + 1);
  localparam int SW = $clog2(MaxNodes + 1);

  // Registers
  state_e           state_q, state_d;
  logic [5:0]       ncfg_q;
  logic [CW-1:0]    etot_q, etot_d;
  logic             drop_q, drop_d;
  logic [MaxNodes-1:0] vis_q, vis_d;
  logic [SW-1:0]    sdep_q, sdep_d;
  logic [NW-1:0]    root_q, root_d;
  logic [NW-1:0]    u_q, u_d;
  logic [CW-1:0]    e_q, e_d;
  logic [NW-1:0]    w_q, w_d;
  logic [NW-1:0]    pu_q, pu_d;
  logic [NW-1:0]    x_q, x_d;
  logic [5:0]       len_q, len_d;
  logic [5:0]       k_q, k_d;
  logic             fnd_q, fnd_d;

  // Effective node count
  logic [6:0] n_eff;
  always_comb begin
    if ({1'b0, ncfg_q} > 7'(MaxNodes)) n_eff = 7'(MaxNodes);
    else n_eff = {1'b0, ncfg_q};
  end

  // Memories: edges, parents, stack (node, position), cycle list
  logic          ed_we;
  logic [EW-1:0] ed_wa, ed_ra;
  logic [2*NW-1:0] ed_wd, ed_rd;
  logic          pl_we;
  logic [NW-1:0] pl_wa, pl_ra, pl_wd, pl_rd;
  logic          st_we;
  logic [NW-1:0] st_wa, st_ra;
  logic [NW+CW-1:0] st_wd, st_rd;
  logic          cy_we;
  logic [5:0]    cy_wa, cy_ra;
  logic [NW-1:0] cy_wd, cy_rd;

  ucf_ram #(.Width(2*NW), .Depth(MaxEdges)) u_edges (
    .clk_i, .we_i(ed_we), .waddr_i(ed_wa), .wdata_i(ed_wd), .raddr_i(ed_ra), .rdata_o(ed_rd));
  ucf_ram #(.Width(NW), .Depth(MaxNodes)) u_parent (
    .clk_i, .we_i(pl_we), .waddr_i(pl_wa), .wdata_i(pl_wd), .raddr_i(pl_ra), .rdata_o(pl_rd));
  ucf_ram #(.Width(NW+CW), .Depth(MaxNodes)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra), .rdata_o(st_rd));
  ucf_ram #(.Width(NW), .Depth(64)) u_cyc (
    .clk_i, .we_i(cy_we), .waddr_i(cy_wa), .wdata_i(cy_wd), .raddr_i(cy_ra), .rdata_o(cy_rd));

  logic accept;
  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  logic [NW-1:0] ea, eb;
  assign ea = ed_rd[2*NW-1:NW];
  assign eb = ed_rd[NW-1:0];

  // Next state and datapath
  always_comb begin
    state_d = state_q; etot_d = etot_q; drop_d = drop_q; vis_d = vis_q;
    sdep_d = sdep_q; root_d = root_q; u_d = u_q; e_d = e_q; w_d = w_q;
    pu_d = pu_q; x_d = x_q; len_d = len_q; k_d = k_q; fnd_d = fnd_q;
    ed_we = 1'b0; ed_wa = etot_q[EW-1:0]; ed_wd = {edge_i.edge_a[NW-1:0], edge_i.edge_b[NW-1:0]};
    ed_ra = e_q[EW-1:0];
    pl_we = 1'b0; pl_wa = w_q; pl_wd = u_q; pl_ra = u_q;
    st_we = 1'b0; st_wa = NW'(sdep_q - SW'(1)); st_wd = {u_q, e_q};
    st_ra = NW'(sdep_q - SW'(1));
    cy_we = 1'b0; cy_wa = len_q; cy_wd = w_q; cy_ra = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (edge_i.has_edge) begin
            if ({2'b0, edge_i.edge_a} >= n_eff || {2'b0, edge_i.edge_b} >= n_eff
                || etot_q >= CW'(MaxEdges)) drop_d = 1'b1;
            else begin
              ed_we = 1'b1; etot_d = etot_q + CW'(1);
            end
          end
          if (edge_i.last_edge) begin
            root_d = '0; len_d = '0; k_d = '0; fnd_d = 1'b0;
            state_d = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (7'(root_q) >= n_eff || n_eff == 7'd0) begin
          state_d = ST_EMIT;
        end else if (vis_q[root_q]) begin
          if (7'(root_q) + 7'd1 >= n_eff) state_d = ST_EMIT;
          else root_d = root_q + NW'(1);
        end else begin
          vis_d[root_q] = 1'b1;
          pl_we = 1'b1; pl_wa = root_q; pl_wd = root_q;
          st_we = 1'b1; st_wa = '0; st_wd = {root_q, CW'(0)};
          sdep_d = SW'(1);
          state_d = ST_TOP;
        end
        cy_ra = '0;
      end
      ST_TOP: begin
        // stack read address presented; data next cycle
        if (sdep_q == '0) begin
          if (7'(root_q) + 7'd1 >= n_eff) state_d = ST_EMIT;
          else begin root_d = root_q + NW'(1); state_d = ST_ROOT; end
          cy_ra = '0;
        end else state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // stack entry valid: latch u and position, start edge read, parent read
        u_d = st_rd[NW+CW-1:CW]; e_d = st_rd[CW-1:0];
        ed_ra = st_rd[EW-1:0];
        pl_ra = st_rd[NW+CW-1:CW];
        if (st_rd[CW-1:0] >= etot_q) begin
          sdep_d = sdep_q - SW'(1); state_d = ST_TOP;
        end else state_d = ST_EDGE;
      end
      ST_EDGE: begin
        // pl_rd is the parent of u on every cycle of the scan
        pl_ra = u_q;
        pu_d = pl_rd;
        if (ea == u_q || eb == u_q) begin
          w_d = (ea == u_q) ? eb : ea;
          st_we = 1'b1; st_wd = {u_q, e_q + CW'(1)};
          pl_ra = (ea == u_q) ? eb : ea;
          state_d = ST_VISIT;
        end else if (e_q + CW'(1) >= etot_q) begin
          sdep_d = sdep_q - SW'(1); state_d = ST_TOP;
        end else begin
          e_d = e_q + CW'(1); ed_ra = EW'(e_q + CW'(1));
        end
      end
      ST_VISIT: begin
        // pl_rd is parent of w; pu_q parent of u
        if (!vis_q[w_q]) begin
          vis_d[w_q] = 1'b1;
          pl_we = 1'b1; pl_wa = w_q; pl_wd = u_q;
          if (sdep_q < SW'(MaxNodes)) begin
            st_we = 1'b1; st_wa = NW'(sdep_q); st_wd = {w_q, CW'(0)};
            sdep_d = sdep_q + SW'(1);
          end
          state_d = ST_TOP;
        end else if (w_q != pu_q) begin
          // cycle opens with w; the walk starts at u
          fnd_d = 1'b1;
          cy_we = 1'b1; cy_wa = 6'd0; cy_wd = w_q;
          x_d = u_q; len_d = 6'd1;
          // w a direct child of u: list is w, u, w
          k_d = (w_q != u_q && pl_rd == u_q) ? 6'd1 : 6'd0;
          state_d = ST_WALK;
        end else state_d = ST_TOP;
      end
      ST_WALK: begin
        // write x and read its parent; write w and emit at the end
        cy_we = 1'b1; cy_wa = len_q;
        if (k_q == 6'd1) begin
          cy_wd = x_q; len_d = len_q + 6'd1; x_d = w_q; k_d = '0;
        end else if (x_q == w_q || len_q > 6'(MaxNodes)) begin
          cy_wd = w_q; len_d = len_q + 6'd1; k_d = '0; cy_ra = '0;
          state_d = ST_EMIT;
        end else begin
          cy_wd = x_q; len_d = len_q + 6'd1; pl_ra = x_q; state_d = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        x_d = pl_rd; state_d = ST_WALK;
      end
      ST_EMIT: begin
        // cy_rd holds entry k_q
        cy_ra = k_q + 6'd1;
        k_d = k_q + 6'd1;
        if (!fnd_q || k_q + 6'd1 >= len_q) begin
          state_d = ST_CLEAR; root_d = '0;
        end
      end
      ST_CLEAR: begin
        vis_d = '0; etot_d = '0; drop_d = 1'b0; sdep_d = '0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output decode
  always_comb begin
    result_valid_o = (state_q == ST_EMIT);
    result_o.found = fnd_q;
    result_o.cycle_length = fnd_q ? len_q : 6'd0;
    result_o.vertex = fnd_q ? cy_rd : 5'd0;
    result_o.overflow = drop_q;
    result_o.last = !fnd_q || (k_q + 6'd1 >= len_q);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ncfg_q <= 6'd32; etot_q <= '0; drop_q <= 1'b0;
      vis_q <= '0; sdep_q <= '0; root_q <= '0; len_q <= '0; k_q <= '0; fnd_q <= 1'b0;
    end else begin
      state_q <= state_d; etot_q <= etot_d; drop_q <= drop_d; vis_q <= vis_d;
      sdep_q <= sdep_d; root_q <= root_d; len_q <= len_d; k_q <= k_d; fnd_q <= fnd_d;
      if (node_count_we_i) ncfg_q <= node_count_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    u_q <= u_d; e_q <= e_d; w_q <= w_d; pu_q <= pu_d; x_q <= x_d;
  end
endmodule

@@ hw/rtl/ucf_checker.sv @@
// Port-level checker for the cycle finder, bound to the top level.
// Depends on ucf_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "undirected_cycle_finder_core_defines.svh"
module ucf_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  result_valid_o,
  input ucf_pkg::result_item_t result_o
);
  import ucf_pkg::*;
  // Results only come while the block is busy.
  `UCF_ASSERT_IMPL(a_res_busy, clk_i, rst_ni, result_valid_o, busy_o)
  // No result in a cycle that takes an edge transaction.
  `UCF_ASSERT_IMPL(a_take_quiet, clk_i, rst_ni, start_i && !busy_o, !result_valid_o)
  // A miss is a single final item.
  `UCF_ASSERT_IMPL(a_miss_last, clk_i, rst_ni, result_valid_o && !result_o.found, result_o.last)
  // A miss reports zero length.
  `UCF_ASSERT_IMPL(a_miss_len, clk_i, rst_ni, result_valid_o && !result_o.found,
    result_o.cycle_length == 6'd0)
  // After the final item the block is in its clear state with no result valid.
  `UCF_ASSERT_NEXT(a_last_done, clk_i, rst_ni, result_valid_o && result_o.last,
    !result_valid_o)
endmodule

bind undirected_cycle_finder_core ucf_checker u_ucf_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .result_valid_o, .result_o);
